FILE: rtl/c2ma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2ma_pkg
// shared constants for the cartesian to magnitude and angles block:
// datapath widths, arctangent table and pi, all in Q40 radians
// ----------------------------------------------------------------------------
package c2ma_pkg;

	localparam int DEF_SAMPLE_BITS     = 16;
	localparam int DEF_ANGLE_FRAC_BITS = 13;
	localparam int DEF_CORDIC_STAGES   = 16;

	localparam int OUT_W   = 16;
	localparam int CORDIC_W = 64;
	localparam int ANG_W   = 44;
	localparam int ANG_FRAC = 40;
	localparam int OP_TOP  = 60;
	localparam int TAB_LEN = 24;

	localparam logic signed [ANG_W-1:0] PI_Q40      = 44'sd3454217652358;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q40 = 44'sd1727108826179;

	localparam logic signed [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
		44'sd863554413089,
		44'sd509785937287,
		44'sd269356888665,
		44'sd136729762476,
		44'sd68630207382,
		44'sd34348560106,
		44'sd17178471287,
		44'sd8589759836,
		44'sd4294945451,
		44'sd2147480917,
		44'sd1073741483,
		44'sd536870869,
		44'sd268435451,
		44'sd134217727,
		44'sd67108864,
		44'sd33554432,
		44'sd16777216,
		44'sd8388608,
		44'sd4194304,
		44'sd2097152,
		44'sd1048576,
		44'sd524288,
		44'sd262144,
		44'sd131072
	};

	typedef struct packed {
		logic den_zero;
		logic num_zero;
		logic den_neg;
		logic num_neg;
	} c2ma_flags_t;

endpackage

FILE: rtl/c2ma_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2ma_cordic
// pipelined vectoring cordic giving full-quadrant atan2(num, den),
// one stage per iteration, rounded to a 16 bit angle
// ----------------------------------------------------------------------------
module c2ma_cordic import c2ma_pkg::*; #(
	parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
	parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
	parameter int CORDIC_STAGES   = DEF_CORDIC_STAGES,
	parameter int LAT             = DEF_CORDIC_STAGES + 3
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [SAMPLE_BITS-1:0] num,
	input  logic signed [SAMPLE_BITS-1:0] den,
	output logic signed [OUT_W-1:0]       angle
);

	localparam int S   = SAMPLE_BITS;
	localparam int N   = CORDIC_STAGES;
	localparam int SH  = OP_TOP - S;
	localparam int DSH = ANG_FRAC - ANGLE_FRAC_BITS;
	localparam int PAD = LAT - (N + 3);
	localparam logic signed [ANG_W-1:0] RND = ANG_W'(64'sd1 <<< (DSH - 1));

	logic signed [S:0] num_e, den_e;
	logic [S:0] an, ad;

	logic signed [CORDIC_W-1:0] x_s [N+1];
	logic signed [CORDIC_W-1:0] y_s [N+1];
	logic signed [ANG_W-1:0]    z_s [N+1];
	c2ma_flags_t                f_s [N+1];

	logic signed [ANG_W-1:0] r_c;
	logic signed [ANG_W-1:0] r_p1;
	logic                    neg_p1;
	logic signed [ANG_W-1:0] q_c, sh_c;
	logic signed [OUT_W-1:0] angle_p2;

	assign num_e = {num[S-1], num};
	assign den_e = {den[S-1], den};
	assign an = num_e[S] ? $unsigned(-num_e) : $unsigned(num_e);
	assign ad = den_e[S] ? $unsigned(-den_e) : $unsigned(den_e);

	// operand prep
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= $signed(CORDIC_W'(ad) << SH);
			y_s[0] <= $signed(CORDIC_W'(an) << SH);
			z_s[0] <= '0;
			f_s[0].den_zero <= (den == '0);
			f_s[0].num_zero <= (num == '0);
			f_s[0].den_neg  <= den[S-1];
			f_s[0].num_neg  <= num[S-1];
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN_TAB[i];
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN_TAB[i];
				end
				f_s[i+1] <= f_s[i];
			end
		end
	end

	// clamp to first quadrant, reflect for negative divisor
	always_comb begin
		logic signed [ANG_W-1:0] zc;
		if (f_s[N].num_zero || z_s[N] < 0) begin
			zc = '0;
		end else if (z_s[N] > HALF_PI_Q40) begin
			zc = HALF_PI_Q40;
		end else begin
			zc = z_s[N];
		end
		if (f_s[N].den_zero) begin
			r_c = f_s[N].num_zero ? '0 : HALF_PI_Q40;
		end else if (f_s[N].den_neg) begin
			r_c = PI_Q40 - zc;
		end else begin
			r_c = zc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_p1   <= r_c;
			neg_p1 <= f_s[N].num_neg;
		end
	end

	// apply sign and round to output format
	assign q_c  = neg_p1 ? -r_p1 : r_p1;
	assign sh_c = (q_c + RND) >>> DSH;

	always_ff @(posedge clk) begin
		if (en) begin
			angle_p2 <= sh_c[OUT_W-1:0];
		end
	end

	if (PAD > 0) begin : g_pad
		logic signed [OUT_W-1:0] dly_q [PAD];
		always_ff @(posedge clk) begin
			if (en) begin
				dly_q[0] <= angle_p2;
				for (int k = 1; k < PAD; k++) begin
					dly_q[k] <= dly_q[k-1];
				end
			end
		end
		assign angle = dly_q[PAD-1];
	end else begin : g_nopad
		assign angle = angle_p2;
	end

endmodule

FILE: rtl/c2ma_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2ma_sqrt
// sum of squares followed by a pipelined restoring square root,
// one result bit per stage, rounded half up and saturated to 16 bits
// ----------------------------------------------------------------------------
module c2ma_sqrt import c2ma_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int LAT         = DEF_SAMPLE_BITS + 3
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [SAMPLE_BITS-1:0] x,
	input  logic signed [SAMPLE_BITS-1:0] y,
	input  logic signed [SAMPLE_BITS-1:0] z,
	output logic [OUT_W-1:0]              magnitude
);

	localparam int S   = SAMPLE_BITS;
	localparam int NW  = 2 * S;
	localparam int MW  = (S + 1 > OUT_W) ? S + 1 : OUT_W;
	localparam int PAD = LAT - (S + 3);

	logic signed [NW-1:0] px_c, py_c, pz_c;
	logic [NW-1:0] sx_s1, sy_s1, sz_s1;
	logic [NW-1:0] rem_s [S+1];
	logic [NW-1:0] res_s [S+1];
	logic [S:0]    rr_c;
	logic [MW-1:0] rw_c;
	logic [OUT_W-1:0] mag_p;

	assign px_c = x * x;
	assign py_c = y * y;
	assign pz_c = z * z;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= $unsigned(px_c);
			sy_s1 <= $unsigned(py_c);
			sz_s1 <= $unsigned(pz_c);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= sx_s1 + sy_s1 + sz_s1;
			res_s[0] <= '0;
		end
	end

	for (genvar j = 0; j < S; j++) begin : g_bit
		localparam logic [NW-1:0] BIT = NW'(1) << (2 * (S - 1 - j));
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[j] >= res_s[j] + BIT) begin
					rem_s[j+1] <= rem_s[j] - (res_s[j] + BIT);
					res_s[j+1] <= (res_s[j] >> 1) + BIT;
				end else begin
					rem_s[j+1] <= rem_s[j];
					res_s[j+1] <= res_s[j] >> 1;
				end
			end
		end
	end

	// round half up, saturate
	assign rr_c = (S+1)'(res_s[S][S-1:0]) + (S+1)'(rem_s[S] > res_s[S]);
	assign rw_c = MW'(rr_c);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_p <= (rw_c > MW'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : rw_c[OUT_W-1:0];
		end
	end

	if (PAD > 0) begin : g_pad
		logic [OUT_W-1:0] dly_q [PAD];
		always_ff @(posedge clk) begin
			if (en) begin
				dly_q[0] <= mag_p;
				for (int k = 1; k < PAD; k++) begin
					dly_q[k] <= dly_q[k-1];
				end
			end
		end
		assign magnitude = dly_q[PAD-1];
	end else begin : g_nopad
		assign magnitude = mag_p;
	end

endmodule

FILE: rtl/cartesian_to_magnitude_angles.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_magnitude_angles
// magnitude and three plane angles of a signed three-axis sample
// ----------------------------------------------------------------------------
// usage
// sample channel: sample_valid / sample_stall with sample_x, sample_y,
//   sample_z; a beat is taken when valid is high and stall is low
// result channel: result_valid / result_stall with magnitude (rounded
//   length) and angle_xy, angle_xz, angle_yz (atan2 in Q3.13 radians)
// pipeline depth: set by the longer of the cordic iteration stages and
//   the one-bit-per-stage root
// throughput: one beat per cycle while no result is held under result_stall, every stage is a register stage
// reset: arst_n clears all stage valid bits, no beat is in flight after it
// stall: while a result waits under result_stall the whole pipeline holds
//   and sample_stall is raised; no beat is lost or repeated
// ----------------------------------------------------------------------------
module cartesian_to_magnitude_angles import c2ma_pkg::*; #(
	parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
	parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
	parameter int CORDIC_STAGES   = DEF_CORDIC_STAGES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_x,
	input  logic signed [SAMPLE_BITS-1:0] sample_y,
	input  logic signed [SAMPLE_BITS-1:0] sample_z,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [OUT_W-1:0]              magnitude,
	output logic signed [OUT_W-1:0]       angle_xy,
	output logic signed [OUT_W-1:0]       angle_xz,
	output logic signed [OUT_W-1:0]       angle_yz
);

	localparam int LAT = ((CORDIC_STAGES > SAMPLE_BITS) ? CORDIC_STAGES : SAMPLE_BITS) + 3;
	localparam int DSH = ANG_FRAC - ANGLE_FRAC_BITS;
	localparam logic signed [ANG_W-1:0] ANG_LIM_W =
		(PI_Q40 + ANG_W'(64'sd1 <<< (DSH - 1))) >>> DSH;
	localparam logic signed [OUT_W-1:0] ANG_LIM = ANG_LIM_W[OUT_W-1:0];

	logic           en;
	logic [LAT-1:0] vld_q;

	assign en           = !(result_valid && result_stall);
	assign sample_stall = !en;
	assign result_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], sample_valid};
		end
	end

	c2ma_sqrt #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.LAT         (LAT)
	) u_sqrt (
		.clk       (clk),
		.en        (en),
		.x         (sample_x),
		.y         (sample_y),
		.z         (sample_z),
		.magnitude (magnitude)
	);

	c2ma_cordic #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.CORDIC_STAGES   (CORDIC_STAGES),
		.LAT             (LAT)
	) u_xy (
		.clk   (clk),
		.en    (en),
		.num   (sample_y),
		.den   (sample_x),
		.angle (angle_xy)
	);

	c2ma_cordic #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.CORDIC_STAGES   (CORDIC_STAGES),
		.LAT             (LAT)
	) u_xz (
		.clk   (clk),
		.en    (en),
		.num   (sample_z),
		.den   (sample_x),
		.angle (angle_xz)
	);

	c2ma_cordic #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.CORDIC_STAGES   (CORDIC_STAGES),
		.LAT             (LAT)
	) u_yz (
		.clk   (clk),
		.en    (en),
		.num   (sample_z),
		.den   (sample_y),
		.angle (angle_yz)
	);

	// pushback only when the output beat is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (result_valid && result_stall))
		else $error("sample_stall without a held result beat");

	// a held result freezes every stage
	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> $stable(vld_q))
		else $error("pipeline moved while result was held");

	// angles stay within plus or minus pi
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && ANGLE_FRAC_BITS <= 13) |->
		(angle_xy <= ANG_LIM && angle_xy >= -ANG_LIM &&
		 angle_xz <= ANG_LIM && angle_xz >= -ANG_LIM &&
		 angle_yz <= ANG_LIM && angle_yz >= -ANG_LIM))
		else $error("angle out of range");

endmodule

FILE: verif/c2ma_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2ma_checker
// watches both channels of the cartesian to magnitude and angles block,
// computes magnitude and plane angles of every accepted sample beat and
// compares each result beat, in order, with the oldest pending prediction
// ----------------------------------------------------------------------------
module c2ma_checker import c2ma_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sample_valid,
	input  logic                    sample_stall,
	input  logic signed [15:0]      sample_x,
	input  logic signed [15:0]      sample_y,
	input  logic signed [15:0]      sample_z,
	input  logic                    result_valid,
	input  logic                    result_stall,
	input  logic [OUT_W-1:0]        magnitude,
	input  logic signed [OUT_W-1:0] angle_xy,
	input  logic signed [OUT_W-1:0] angle_xz,
	input  logic signed [OUT_W-1:0] angle_yz,
	output int                      errors,
	output int                      pending,
	output int                      results_seen
);

	localparam int SBITS  = 16;
	localparam int AFRAC  = 13;
	localparam int STAGES = 16;

	typedef struct packed {
		logic [15:0] mag;
		logic [15:0] xy;
		logic [15:0] xz;
		logic [15:0] yz;
	} polar_t;

	polar_t polar_q[$];

	function automatic longint floor_sh(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint atan2_q40(longint num, longint den);
		longint an, ad, z, r, xv, yv, xs, ys;
		if (den == 0) begin
			if (num == 0)
				return 0;
			return num > 0 ? longint'(HALF_PI_Q40) : -longint'(HALF_PI_Q40);
		end
		an = num < 0 ? -num : num;
		ad = den < 0 ? -den : den;
		z = 0;
		if (an != 0) begin
			xv = ad <<< (OP_TOP - SBITS);
			yv = an <<< (OP_TOP - SBITS);
			for (int i = 0; i < STAGES && i < TAB_LEN; i++) begin
				xs = floor_sh(xv, i);
				ys = floor_sh(yv, i);
				if (yv > 0) begin
					xv += ys; yv -= xs; z += longint'(ATAN_TAB[i]);
				end else begin
					xv -= ys; yv += xs; z -= longint'(ATAN_TAB[i]);
				end
			end
			if (z < 0)
				z = 0;
			if (z > longint'(HALF_PI_Q40))
				z = HALF_PI_Q40;
		end
		r = den < 0 ? longint'(PI_Q40) - z : z;
		if (r < 0)
			r = 0;
		if (r > longint'(PI_Q40))
			r = PI_Q40;
		return num < 0 ? -r : r;
	endfunction

	function automatic logic [15:0] to_q13(longint q40);
		longint v;
		v = floor_sh(q40 + (longint'(1) <<< (ANG_FRAC - 1 - AFRAC)), ANG_FRAC - AFRAC);
		return v[15:0];
	endfunction

	function automatic logic [15:0] rounded_length(longint x, longint y, longint z);
		longint unsigned n, res;
		n = x * x + y * y + z * z;
		res = 0;
		for (longint unsigned b = 1 << 17; b > 0; b >>= 1)
			if ((res + b) * (res + b) <= n)
				res += b;
		if (n - res * res > res)
			res++;
		if (res > 65535)
			res = 65535;
		return res[15:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		polar_t p, got;
		if (!arst_n) begin
			errors <= 0;
			results_seen <= 0;
			polar_q.delete();
		end else begin
			if (sample_valid && !sample_stall) begin
				p.mag = rounded_length(sample_x, sample_y, sample_z);
				p.xy  = to_q13(atan2_q40(sample_y, sample_x));
				p.xz  = to_q13(atan2_q40(sample_z, sample_x));
				p.yz  = to_q13(atan2_q40(sample_z, sample_y));
				polar_q.push_back(p);
			end
			if (result_valid && !result_stall) begin
				results_seen <= results_seen + 1;
				got.mag = magnitude;
				got.xy  = angle_xy;
				got.xz  = angle_xz;
				got.yz  = angle_yz;
				if (polar_q.size() == 0) begin
					$display("%0t: result beat with nothing expected", $time);
					errors <= errors + 1;
				end else begin
					p = polar_q.pop_front();
					if (got != p) begin
						$display("%0t: mismatch exp mag %0d xy %0d xz %0d yz %0d", $time,
							p.mag, $signed(p.xy), $signed(p.xz), $signed(p.yz));
						$display("%0t:          got mag %0d xy %0d xz %0d yz %0d", $time,
							got.mag, $signed(got.xy), $signed(got.xz), $signed(got.yz));
						errors <= errors + 1;
					end
				end
			end
		end
	end

	assign pending = polar_q.size();

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives directed and random three-axis samples through the cartesian to
// magnitude and angles block under several idle and stall mixes
// ----------------------------------------------------------------------------
module tb import c2ma_pkg::*; ;

	localparam int LATENCY = 19;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic signed [15:0] sample_x = '0, sample_y = '0, sample_z = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [OUT_W-1:0] magnitude;
	logic signed [OUT_W-1:0] angle_xy, angle_xz, angle_yz;
	int errors, pending, results_seen;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_off = 0;
	int beats_sent = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	cartesian_to_magnitude_angles dut (.*);

	c2ma_checker chk (.*);

	always @(posedge clk) begin
		if (hold_off > 0) begin
			result_stall <= 1;
			hold_off <= hold_off - 1;
		end else
			result_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic logic [15:0] pick_axis();
		case ($urandom_range(7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'h0000;
			3: return 16'($urandom_range(7) - 4);
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		while ($urandom_range(99) < idle_pct) begin
			sample_valid <= 0;
			@(posedge clk);
		end
		sample_valid <= 1;
		sample_x <= x;
		sample_y <= y;
		sample_z <= z;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		beats_sent++;
	endtask

	initial begin
		logic [15:0] corner [5];
		corner = '{16'sh8000, 16'sh7fff, 16'h0000, 16'h0001, 16'hffff};
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int i = 0; i < 5; i++)
			for (int j = 0; j < 5; j++)
				send_sample(corner[i], corner[j], corner[(i + j) % 5]);
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = (ph == 1) ? 73 : (ph == 3) ? 33 : 0;
			stall_pct = (ph == 2) ? 73 : (ph == 3) ? 33 : 0;
			if (ph == 0)
				hold_off <= 60;
			for (int n = 0; n < 200; n++)
				send_sample(pick_axis(), pick_axis(), pick_axis());
			sample_valid <= 0;
			@(posedge clk);
		end
		sample_valid <= 0;
		stall_pct = 0;
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		$display("sent %0d sample beats, checked %0d result beats", beats_sent, results_seen);
		$display("covered axis extremes, zero operands and four idle/stall mixes");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#500000;
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/c2ma_pkg.sv
rtl/c2ma_cordic.sv
rtl/c2ma_sqrt.sv
rtl/cartesian_to_magnitude_angles.sv
verif/c2ma_checker.sv
verif/tb.sv
